FILE: src/hsmc_pkg.sv
// Package for the hard-sphere Monte Carlo move engine.
// Holds opcodes, controller states and the controller/datapath command structs.
package hsmc_pkg;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_MOVE = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [2:0] CSR_BOX_X  = 3'd0;
   localparam logic [2:0] CSR_BOX_Y  = 3'd1;
   localparam logic [2:0] CSR_BOX_Z  = 3'd2;
   localparam logic [2:0] CSR_COUNT  = 3'd3;
   localparam logic [2:0] CSR_STEP   = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_FETCH_WAIT,
      ST_FOLD,
      ST_SCAN_RD,
      ST_SCAN_SQ,
      ST_SCAN_SUM,
      ST_SCAN_CMP,
      ST_COMMIT,
      ST_RESP_RD,
      ST_RESP_WAIT,
      ST_RESP
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;     // latch the input item
      logic rd_self;     // read addressed sphere's entry
      logic fold;        // compute trial position
      logic scan_start;  // reset the scan counters
      logic rd_other;    // read entry at scan index
      logic square;      // form mirrored deltas
      logic sum;         // form squared deltas
      logic compare;     // test and advance mirror/index
      logic write_load;  // write loaded position
      logic write_move;  // commit trial state
      logic set_zero;    // out-of-range sphere result
      logic out_load;    // capture response from read data
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [1:0] opcode;
      logic       out_of_range;
      logic       scan_done;
      logic       hit;
      logic       skip_self;
   } stat_type;

endpackage

FILE: src/hsmc_ctrl.sv
// Controller state machine for the hard-sphere move engine.
// Depends on hsmc_pkg for the state and command types.
module hsmc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output hsmc_pkg::cmd_type   cmd,
   input  hsmc_pkg::stat_type  stat
);

   hsmc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hsmc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hsmc_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = hsmc_pkg::ST_FETCH;
         end
         hsmc_pkg::ST_FETCH: begin
            if (stat.out_of_range) state_in = hsmc_pkg::ST_RESP;
            else if (stat.opcode == hsmc_pkg::OP_LOAD) state_in = hsmc_pkg::ST_RESP_RD;
            else state_in = hsmc_pkg::ST_FETCH_WAIT;
         end
         hsmc_pkg::ST_FETCH_WAIT: begin
            if (stat.opcode == hsmc_pkg::OP_MOVE) state_in = hsmc_pkg::ST_FOLD;
            else state_in = hsmc_pkg::ST_RESP_WAIT;
         end
         hsmc_pkg::ST_FOLD:     state_in = hsmc_pkg::ST_SCAN_RD;
         hsmc_pkg::ST_SCAN_RD: begin
            if (stat.scan_done) state_in = hsmc_pkg::ST_COMMIT;
            else if (stat.skip_self) state_in = hsmc_pkg::ST_SCAN_RD;
            else state_in = hsmc_pkg::ST_SCAN_SQ;
         end
         hsmc_pkg::ST_SCAN_SQ:  state_in = hsmc_pkg::ST_SCAN_SUM;
         hsmc_pkg::ST_SCAN_SUM: state_in = hsmc_pkg::ST_SCAN_CMP;
         hsmc_pkg::ST_SCAN_CMP: begin
            if (stat.hit) state_in = hsmc_pkg::ST_RESP_RD;
            else state_in = hsmc_pkg::ST_SCAN_RD;
         end
         hsmc_pkg::ST_COMMIT:    state_in = hsmc_pkg::ST_RESP_RD;
         hsmc_pkg::ST_RESP_RD:   state_in = hsmc_pkg::ST_RESP_WAIT;
         hsmc_pkg::ST_RESP_WAIT: state_in = hsmc_pkg::ST_RESP;
         hsmc_pkg::ST_RESP: begin
            if (rsp_tready) state_in = hsmc_pkg::ST_IDLE;
         end
         default: state_in = hsmc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         hsmc_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         hsmc_pkg::ST_FETCH: begin
            cmd.rd_self    = 1'b1;
            cmd.write_load = !stat.out_of_range && stat.opcode == hsmc_pkg::OP_LOAD;
            cmd.set_zero   = stat.out_of_range;
         end
         hsmc_pkg::ST_FOLD: begin
            cmd.fold       = 1'b1;
            cmd.scan_start = 1'b1;
         end
         hsmc_pkg::ST_SCAN_RD:  cmd.rd_other = 1'b1;
         hsmc_pkg::ST_SCAN_SQ:  cmd.square = 1'b1;
         hsmc_pkg::ST_SCAN_SUM: cmd.sum = 1'b1;
         hsmc_pkg::ST_SCAN_CMP: cmd.compare = 1'b1;
         hsmc_pkg::ST_COMMIT:   cmd.write_move = 1'b1;
         hsmc_pkg::ST_RESP_RD:  cmd.rd_self = 1'b1;
         hsmc_pkg::ST_RESP_WAIT: cmd.out_load = 1'b1;
         hsmc_pkg::ST_RESP:     rsp_tvalid = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

FILE: src/hsmc_dp.sv
// Datapath of the hard-sphere move engine: sphere memories, fold logic,
// mirror-image distance pipeline, lap-counter clear sweep, response register.
// Depends on hsmc_pkg for command and status types.
module hsmc_dp #(
   parameter int MAX_SPHERES  = 1024,
   parameter int MIRROR_RANGE = 1,
   parameter int FRAC_BITS    = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic [95:0]        req_tdata,
   input  hsmc_pkg::cmd_type  cmd,
   output hsmc_pkg::stat_type stat,
   output logic               clr_busy,
   output logic [103:0]       rsp_tdata
);

   localparam int IW = $clog2(MAX_SPHERES);
   localparam int CW = IW + 1;
   localparam int MW = $clog2(2 * MIRROR_RANGE + 1) + 1;
   localparam int DW = 20;   // signed span of mirrored delta
   localparam int SW = 2 * DW + 2;
   localparam logic signed [MW-1:0] MLO = MW'(-MIRROR_RANGE);
   localparam logic signed [MW-1:0] MHI = MW'(MIRROR_RANGE);

   // configuration
   logic [15:0] box_x_ff, box_y_ff, box_z_ff;
   logic [10:0] count_ff;
   logic [12:0] step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= 16'd7168;
         box_y_ff <= 16'd7168;
         box_z_ff <= 16'd7168;
         count_ff <= 11'd25;
         step_ff  <= 13'd205;
      end else if (csr_valid) begin
         case (csr_index)
            hsmc_pkg::CSR_BOX_X: box_x_ff <= csr_data;
            hsmc_pkg::CSR_BOX_Y: box_y_ff <= csr_data;
            hsmc_pkg::CSR_BOX_Z: box_z_ff <= csr_data;
            hsmc_pkg::CSR_COUNT: count_ff <= csr_data[10:0];
            hsmc_pkg::CSR_STEP:  step_ff  <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // captured item
   logic [1:0]  op_ff;
   logic [9:0]  sph_ff;
   logic [47:0] load_ff;
   logic [29:0] rand_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_tdata[1:0];
         sph_ff  <= req_tdata[11:2];
         load_ff <= req_tdata[59:12];
         rand_ff <= req_tdata[89:60];
      end
   end
   logic [IW-1:0] self_idx;
   logic          oor;
   assign oor      = ({6'd0, sph_ff} >= 16'(MAX_SPHERES));
   assign self_idx = IW'(sph_ff);

   // memories
   logic [47:0] pos_mem [MAX_SPHERES];
   logic [47:0] lap_mem [MAX_SPHERES];
   logic [47:0] pos_rd_ff, lap_rd_ff;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] scan_idx;
   logic [IW-1:0] clr_idx_ff;
   logic          clr_busy_ff;
   logic [47:0] trial_pos_ff, trial_lap_ff;

   assign rd_addr = cmd.rd_other ? scan_idx : self_idx;

   always_ff @(posedge clock) begin
      if (cmd.write_load) pos_mem[self_idx] <= load_ff;
      else if (cmd.write_move) pos_mem[self_idx] <= trial_pos_ff;
      pos_rd_ff <= pos_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) lap_mem[clr_idx_ff] <= '0;
      else if (cmd.write_move) lap_mem[self_idx] <= trial_lap_ff;
      lap_rd_ff <= lap_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == IW'(MAX_SPHERES - 1)) clr_busy_ff <= 1'b0;
      end
   end
   assign clr_busy = clr_busy_ff;

   // fold: delta = floor((r-512)*step/1024)
   function automatic logic signed [17:0] delta_f(input logic [9:0] r,
                                                  input logic [12:0] st);
      logic signed [24:0] p;
      begin
         p = ($signed({1'b0, r}) - 11'sd512) * $signed({1'b0, st});
         delta_f = 18'(p >>> 10);
      end
   endfunction

   function automatic logic [31:0] fold_f(input logic [15:0] pos,
                                          input logic [15:0] lap,
                                          input logic signed [17:0] d,
                                          input logic [15:0] box);
      logic signed [18:0] p;
      logic [15:0] l;
      begin
         p = $signed({3'd0, pos}) + 19'(d);
         l = lap;
         if (p > $signed({3'd0, box})) begin
            p = p - $signed({3'd0, box});
            l = l + 16'd1;
         end
         if (p < 0) begin
            p = p + $signed({3'd0, box});
            l = l - 16'd1;
         end
         fold_f = {l, p[15:0]};
      end
   endfunction

   logic [31:0] fx, fy, fz;
   always_comb begin
      fx = fold_f(pos_rd_ff[15:0],  lap_rd_ff[15:0],
                  delta_f(rand_ff[9:0], step_ff), box_x_ff);
      fy = fold_f(pos_rd_ff[31:16], lap_rd_ff[31:16],
                  delta_f(rand_ff[19:10], step_ff), box_y_ff);
      fz = fold_f(pos_rd_ff[47:32], lap_rd_ff[47:32],
                  delta_f(rand_ff[29:20], step_ff), box_z_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.fold) begin
         trial_pos_ff <= {fz[15:0], fy[15:0], fx[15:0]};
         trial_lap_ff <= {fz[31:16], fy[31:16], fx[31:16]};
      end
   end

   // scan over spheres and mirror images
   logic [CW-1:0] limit_cnt;
   assign limit_cnt = (32'(count_ff) > 32'(MAX_SPHERES)) ? CW'(MAX_SPHERES)
                                                         : CW'(count_ff);

   logic [CW-1:0] scan_cnt_ff;
   logic signed [MW-1:0] mx_ff, my_ff, mz_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, dz_ff;
   logic [SW-1:0] sx_ff, sy_ff, sz_ff;
   logic last_img;

   assign last_img = (mx_ff == MHI) && (my_ff == MHI) && (mz_ff == MHI);

   function automatic logic signed [DW-1:0] md(input logic signed [MW-1:0] m,
                                               input logic [15:0] box,
                                               input logic [15:0] a,
                                               input logic [15:0] b);
      logic signed [DW-1:0] o;
      begin
         o = (m == 0) ? DW'(0) : (m > 0 ? $signed(DW'(box)) : -$signed(DW'(box)));
         if (m > 1) o = o + $signed(DW'(box));
         if (m < -1) o = o - $signed(DW'(box));
         md = o + $signed(DW'(a)) - $signed(DW'(b));
      end
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_cnt_ff <= '0;
         mx_ff <= MLO; my_ff <= MLO; mz_ff <= MLO;
      end else if (cmd.rd_other) begin
         if (stat.skip_self) scan_cnt_ff <= scan_cnt_ff + 1'b1;
      end else if (cmd.square) begin
         dx_ff <= md(mx_ff, box_x_ff, trial_pos_ff[15:0],  pos_rd_ff[15:0]);
         dy_ff <= md(my_ff, box_y_ff, trial_pos_ff[31:16], pos_rd_ff[31:16]);
         dz_ff <= md(mz_ff, box_z_ff, trial_pos_ff[47:32], pos_rd_ff[47:32]);
      end else if (cmd.sum) begin
         sx_ff <= SW'(dx_ff * dx_ff);
         sy_ff <= SW'(dy_ff * dy_ff);
         sz_ff <= SW'(dz_ff * dz_ff);
      end else if (cmd.compare) begin
         if (last_img) begin
            mx_ff <= MLO; my_ff <= MLO; mz_ff <= MLO;
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end else if (mz_ff != MHI) begin
            mz_ff <= mz_ff + 1'b1;
         end else begin
            mz_ff <= MLO;
            if (my_ff != MHI) my_ff <= my_ff + 1'b1;
            else begin
               my_ff <= MLO;
               mx_ff <= mx_ff + 1'b1;
            end
         end
      end
   end
   assign scan_idx = IW'(scan_cnt_ff);

   logic hit_now;
   assign hit_now = (sx_ff + sy_ff + sz_ff) < (SW'(1) << (2 * FRAC_BITS));

   // response
   logic [103:0] rsp_ff;
   logic         acc_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 1'b0;
      end else if (cmd.capture) begin
         acc_ff <= 1'b0;
      end else if (cmd.write_move) begin
         acc_ff <= 1'b1;
      end
      if (cmd.set_zero) rsp_ff <= '0;
      else if (cmd.out_load) rsp_ff <= {7'd0, lap_rd_ff, pos_rd_ff, acc_ff};
   end
   assign rsp_tdata = rsp_ff;

   always_comb begin
      stat              = '0;
      stat.opcode       = op_ff;
      stat.out_of_range = oor;
      stat.scan_done    = scan_cnt_ff >= limit_cnt;
      stat.skip_self    = ({1'b0, scan_idx} == CW'(self_idx)) &&
                          (scan_cnt_ff < limit_cnt);
      stat.hit          = hit_now;
   end
endmodule

FILE: src/hard_sphere_monte_carlo_move.sv
// Hard-sphere Metropolis move engine, periodic box, one item at a time.
// A move scans the other spheres below n = min(sphere_count, MAX_SPHERES), each through 27
// mirror images (MIRROR_RANGE 1) x 4 pipeline steps; if the moved sphere is at or above n,
// all n are scanned; a reject stops at the overlapping image. The next item can be accepted
// in the cycle after the response handshake. Reset: synchronous; lap counters cleared by a
// sweep over all MAX_SPHERES entries during which no item is taken; registers to defaults.
module hard_sphere_monte_carlo_move #(
   parameter int MAX_SPHERES  = 1024,
   parameter int MIRROR_RANGE = 1,
   parameter int FRAC_BITS    = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[1:0], sphere[11:2], load_x, load_y, load_z, rand_x, rand_y, rand_z[89:80], pad
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // accepted[0], pos_x, pos_y, pos_z, laps_x, laps_y, laps_z
   output logic [103:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);

   hsmc_pkg::cmd_type  cmd;
   hsmc_pkg::stat_type stat;
   logic clr_busy;
   logic req_ready_c;

   assign csr_ready  = 1'b1;
   assign req_tready = req_ready_c && !clr_busy;

   hsmc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid && !clr_busy), .req_tready(req_ready_c),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .cmd(cmd), .stat(stat)
   );

   hsmc_dp #(.MAX_SPHERES(MAX_SPHERES), .MIRROR_RANGE(MIRROR_RANGE),
             .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .req_tdata(req_tdata), .cmd(cmd), .stat(stat),
      .clr_busy(clr_busy), .rsp_tdata(rsp_tdata)
   );

endmodule

FILE: tb/hard_sphere_monte_carlo_move_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the hard-sphere Monte Carlo move engine.
// Needs hsmc_pkg and hard_sphere_monte_carlo_move; predicts each response in a scoreboard class.
module hard_sphere_monte_carlo_move_tb;

   // opcode three is served as a read
   localparam logic [1:0] OP_READ_ALT = 2'd3;
   localparam int NSPH = 1024;
   localparam longint CYCLE_LIMIT = 6000000;

   typedef struct {
      logic [1:0]  op;
      logic [9:0]  sphere;
      logic [15:0] lx, ly, lz;
      logic [9:0]  rx, ry, rz;
   } move_req_type;

   typedef struct {
      logic        accepted;
      logic [15:0] px, py, pz;
      logic [15:0] kx, ky, kz;
   } sphere_state_type;

   // Scoreboard: own copy of the sphere store and registers, queue of expected responses.
   class move_scoreboard;
      logic [15:0] pos_x[NSPH], pos_y[NSPH], pos_z[NSPH];
      logic [15:0] laps_x[NSPH], laps_y[NSPH], laps_z[NSPH];
      int unsigned box_x, box_y, box_z, count, step;
      sphere_state_type expected_q[$];
      int errors;

      function new();
         for (int i = 0; i < NSPH; i++) begin
            pos_x[i] = '0; pos_y[i] = '0; pos_z[i] = '0;
            laps_x[i] = '0; laps_y[i] = '0; laps_z[i] = '0;
         end
         box_x = 7168; box_y = 7168; box_z = 7168;
         count = 25; step = 205;
         errors = 0;
      endfunction

      function void write_register(logic [2:0] idx, logic [15:0] v);
         case (idx)
            hsmc_pkg::CSR_BOX_X: box_x = 32'(v);
            hsmc_pkg::CSR_BOX_Y: box_y = 32'(v);
            hsmc_pkg::CSR_BOX_Z: box_z = 32'(v);
            hsmc_pkg::CSR_COUNT: count = 32'(v[10:0]);
            hsmc_pkg::CSR_STEP:  step = 32'(v[12:0]);
            default: ;
         endcase
      endfunction

      // floor((r - 512) * step / 1024); arithmetic shift floors negatives
      function int displacement(logic [9:0] r);
         int p;
         p = (int'(r) - 512) * int'(step);
         return p >>> 10;
      endfunction

      function void wrap_axis(input logic [15:0] pos, input logic [15:0] laps, input int d,
                              input int unsigned box, output logic [15:0] np,
                              output logic [15:0] nl);
         int p;
         p = int'(pos) + d;
         nl = laps;
         if (p > int'(box)) begin
            p -= int'(box);
            nl = nl + 16'd1;
         end
         if (p < 0) begin
            p += int'(box);
            nl = nl - 16'd1;
         end
         np = p[15:0];
      endfunction

      function bit collides(int self, logic [15:0] px, logic [15:0] py, logic [15:0] pz);
         int lim;
         longint dx, dy, dz;
         lim = (count > NSPH) ? NSPH : count;
         for (int i = 0; i < lim; i++) begin
            if (i == self) continue;
            for (int mx = -1; mx <= 1; mx++)
               for (int my = -1; my <= 1; my++)
                  for (int mz = -1; mz <= 1; mz++) begin
                     dx = longint'(mx) * box_x + px - longint'(pos_x[i]);
                     dy = longint'(my) * box_y + py - longint'(pos_y[i]);
                     dz = longint'(mz) * box_z + pz - longint'(pos_z[i]);
                     if (dx * dx + dy * dy + dz * dz < (64'd1 << 20)) return 1'b1;
                  end
         end
         return 1'b0;
      endfunction

      function void note_request(move_req_type r);
         sphere_state_type e;
         logic [15:0] nx, ny, nz, kx, ky, kz;
         int s;
         s = int'(r.sphere);
         e.accepted = 1'b0;
         if (r.op == hsmc_pkg::OP_LOAD) begin
            pos_x[s] = r.lx; pos_y[s] = r.ly; pos_z[s] = r.lz;
         end else if (r.op == hsmc_pkg::OP_MOVE) begin
            wrap_axis(pos_x[s], laps_x[s], displacement(r.rx), box_x, nx, kx);
            wrap_axis(pos_y[s], laps_y[s], displacement(r.ry), box_y, ny, ky);
            wrap_axis(pos_z[s], laps_z[s], displacement(r.rz), box_z, nz, kz);
            if (!collides(s, nx, ny, nz)) begin
               pos_x[s] = nx; pos_y[s] = ny; pos_z[s] = nz;
               laps_x[s] = kx; laps_y[s] = ky; laps_z[s] = kz;
               e.accepted = 1'b1;
            end
         end
         e.px = pos_x[s]; e.py = pos_y[s]; e.pz = pos_z[s];
         e.kx = laps_x[s]; e.ky = laps_y[s]; e.kz = laps_z[s];
         expected_q.push_back(e);
      endfunction

      task report(string what, logic [15:0] got, logic [15:0] want);
         $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
         errors++;
      endtask

      task check_result(logic [103:0] d);
         sphere_state_type e;
         if (expected_q.size() == 0) begin
            report("unexpected response", d[15:0], 16'h0);
            return;
         end
         e = expected_q.pop_front();
         if (d[0] !== e.accepted) report("accepted", 16'(d[0]), 16'(e.accepted));
         if (d[16:1] !== e.px) report("pos_x", d[16:1], e.px);
         if (d[32:17] !== e.py) report("pos_y", d[32:17], e.py);
         if (d[48:33] !== e.pz) report("pos_z", d[48:33], e.pz);
         if (d[64:49] !== e.kx) report("laps_x", d[64:49], e.kx);
         if (d[80:65] !== e.ky) report("laps_y", d[80:65], e.ky);
         if (d[96:81] !== e.kz) report("laps_z", d[96:81], e.kz);
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid, req_tready;
   logic [95:0]  req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [103:0] rsp_tdata;
   logic         csr_valid, csr_ready;
   logic [2:0]   csr_index;
   logic [15:0]  csr_data;

   move_scoreboard sb;
   bit   loaded[NSPH];  // position entries written so far
   bit   quiet;         // phase runs without idling on either side
   bit   req_held;      // req_tvalid left high after the last item
   longint cycles = 0;

   hard_sphere_monte_carlo_move u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("hard_sphere_monte_carlo_move regression: fail");
         $finish;
      end
   end

   // response side: sample at the edge, before any update lands
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver stalls
   initial begin
      int hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) hold--;
         else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            hold = pick_gap();
         end else rsp_tready <= 1'b1;
      end
   end

   // tdata: opcode, sphere, load_x, load_y, load_z, rand_x, rand_y, rand_z from bit 0 up
   function automatic logic [95:0] pack_request(move_req_type r);
      return {6'b0, r.rz, r.ry, r.rx, r.lz, r.ly, r.lx, r.sphere, r.op};
   endfunction

   task automatic stop_requests();
      if (req_held) begin
         req_tvalid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   task automatic send_item(move_req_type r);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         stop_requests();
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= pack_request(r);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_held = 1'b1;
      if (r.op == hsmc_pkg::OP_LOAD) loaded[r.sphere] = 1'b1;
      sb.note_request(r);
   endtask

   // always moves past the current step so a following raise of valid is separate
   task automatic drain_responses();
      stop_requests();
      do @(posedge clock); while (sb.expected_q.size() != 0);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] v);
      drain_responses();
      csr_index <= idx;
      csr_data  <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.write_register(idx, v);
   endtask

   function automatic move_req_type make_item(logic [1:0] op, int s);
      move_req_type r;
      r.op = op; r.sphere = 10'(s);
      r.lx = 16'($urandom); r.ly = 16'($urandom); r.lz = 16'($urandom);
      r.rx = 10'($urandom); r.ry = 10'($urandom); r.rz = 10'($urandom);
      return r;
   endfunction

   task automatic load(int s, int x, int y, int z);
      move_req_type r;
      r = make_item(hsmc_pkg::OP_LOAD, s);
      r.lx = 16'(x); r.ly = 16'(y); r.lz = 16'(z);
      send_item(r);
   endtask

   task automatic move(int s, int rx, int ry, int rz);
      move_req_type r;
      r = make_item(hsmc_pkg::OP_MOVE, s);
      r.rx = 10'(rx); r.ry = 10'(ry); r.rz = 10'(rz);
      send_item(r);
   endtask

   // a sphere whose entry has been written; mostly within the tested range
   function automatic int pick_sphere(int lim);
      int s;
      if (lim > 0 && $urandom_range(0, 9) != 0) return $urandom_range(0, lim - 1);
      for (int t = 0; t < 50; t++) begin
         s = $urandom_range(0, NSPH - 1);
         if (loaded[s]) return s;
      end
      return 0;
   endfunction

   task automatic load_in_box(int s);
      int bx, by, bz;
      bx = sb.box_x; by = sb.box_y; bz = sb.box_z;
      if ($urandom_range(0, 9) == 0) load(s, $urandom, $urandom, $urandom);
      else load(s, $urandom_range(0, bx), $urandom_range(0, by), $urandom_range(0, bz));
   endtask

   task automatic run_phase(int bx, int by, int bz, int cnt, int stp, int n, bit squeeze);
      int lim, r, s;
      move_req_type q;
      write_csr(hsmc_pkg::CSR_BOX_X, 16'(bx));
      write_csr(hsmc_pkg::CSR_BOX_Y, 16'(by));
      write_csr(hsmc_pkg::CSR_BOX_Z, 16'(bz));
      write_csr(hsmc_pkg::CSR_COUNT, 16'(cnt));
      write_csr(hsmc_pkg::CSR_STEP, 16'(stp));
      quiet = ($urandom_range(0, 3) == 0);
      lim = (cnt > NSPH) ? NSPH : cnt;
      // every sphere a move is tested against must hold a position
      for (int i = 0; i < lim; i++) load_in_box(i);
      for (int k = 0; k < n; k++) begin
         if (squeeze && k == n / 2) drain_responses();
         r = $urandom_range(0, 99);
         if (r < 60) move(pick_sphere(lim), $urandom, $urandom, $urandom);
         else if (r < 75) begin
            s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NSPH - 1)
                                            : ((lim > 0) ? $urandom_range(0, lim - 1) : 0);
            load_in_box(s);
         end else begin
            q = make_item((r < 90) ? hsmc_pkg::OP_READ : OP_READ_ALT, pick_sphere(lim));
            send_item(q);
         end
      end
   endtask

   initial begin
      move_req_type q;
      sb = new();
      quiet = 1'b0;
      req_held = 1'b0;
      for (int i = 0; i < NSPH; i++) loaded[i] = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= hsmc_pkg::CSR_BOX_X;
      csr_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: four spheres, default box and step
      write_csr(hsmc_pkg::CSR_COUNT, 16'd4);
      load(0, 1024, 1024, 1024);
      load(1, 4096, 4096, 4096);
      load(2, 7168, 0, 3500);          // on the upper x face and the lower y face
      load(3, 2048, 6000, 6500);
      move(2, 1023, 1023, 1023);       // crosses upward in x
      move(2, 0, 0, 0);                // largest negative step, crosses back
      move(1, 512, 512, 512);          // zero displacement
      load(3, 4500, 4096, 4096);       // close to sphere 1
      move(3, 600, 512, 400);          // overlap, rejected
      q = make_item(hsmc_pkg::OP_READ, 0); send_item(q);
      q = make_item(OP_READ_ALT, 1); send_item(q);
      load(1023, 65535, 65535, 65535); // above the count, outside the box
      move(1023, 1023, 0, 1023);
      q = make_item(hsmc_pkg::OP_READ, 1023); send_item(q);
      load(1023, 0, 0, 0);
      move(1023, 0, 1023, 0);          // below zero, folds up
      move(0, 1023, 0, 512);

      run_phase(7168, 7168, 7168, 25, 205, 100, 1'b0);
      run_phase(1024, 1024, 1024, 0, 8191, 60, 1'b0);    // nothing tested, all commit
      run_phase(65535, 65535, 65535, 3, 8191, 100, 1'b0);
      run_phase(3000, 5000, 2048, 6, 1024, 120, 1'b1);
      run_phase(1024, 2000, 1500, 2, 300, 80, 1'b0);     // crowded, many rejects
      run_phase(12000, 12000, 12000, 8, 4000, 120, 1'b0);
      run_phase(7168, 7168, 7168, 1, 0, 60, 1'b0);       // no displacement
      run_phase(8192, 8192, 8192, 5, 2500, 150, 1'b0);
      q = make_item(hsmc_pkg::OP_MOVE, 5); send_item(q);

      drain_responses();
      repeat (50) @(posedge clock);
      if (sb.errors == 0) $display("hard_sphere_monte_carlo_move regression: pass");
      else $display("hard_sphere_monte_carlo_move regression: fail");
      $finish;
   end

endmodule
